@@ rtl/rpn_stack_calculator_assert.svh @@
// Assertion macros for the calculator RTL (included by the back end).
`ifndef RPN_STACK_CALCULATOR_ASSERT_SVH
`define RPN_STACK_CALCULATOR_ASSERT_SVH

// Condition must hold at every edge outside reset.
`define RSC_ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define RSC_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RSC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/rsc_pkg.sv @@
// Shared types and constants of the RPN calculator.
`timescale 1ns / 1ps

package rsc_pkg;

  localparam int DATA_W      = 32;
  localparam int STATUS_W    = 3;
  localparam int DIGIT_W     = 4;
  // Command queue between front and back; must stay a power of two
  localparam int QUEUE_DEPTH = 2;

  // Character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5A;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DIVZERO   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ABORT     = 3'd4;

  // Decoded command
  typedef enum logic [2:0] {
    OP_SKIP,
    OP_PUSH,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_EQ,
    OP_ABORT
  } op_t;

  // One queued request
  typedef struct packed {
    op_t                op;
    logic [DIGIT_W-1:0] digit;
  } cmd_t;

endpackage

@@ rtl/rpn_stack_calculator.sv @@
// A digit is pushed straight from idle; + - * go through execute, / through execute and the
// iterative divider (one bit per cycle), the slowest step; = or an error goes via emit to the
// output register. Commands are taken in idle only; a 2-entry queue lets input run ahead.
// Reset (rst, synchronous): empties the stack, queue and output register; stack
// memory contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module rpn_stack_calculator import rsc_pkg::*; #(
  parameter int STACK_DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               char_code,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] value,
  output logic [STATUS_W-1:0]      status
);

  logic q_full;
  logic q_push;
  cmd_t q_cmd;
  logic q_pop;
  logic q_valid;
  cmd_t q_head;

  rsc_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_code (char_code),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  rsc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_head)
  );

  rsc_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .status    (status)
  );

endmodule

@@ rtl/rsc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/rsc_front.sv @@
// Front end: takes characters and decodes them into stack commands.
`timescale 1ns / 1ps

module rsc_front import rsc_pkg::*; (
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_code,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);

  // Map one character to a command; whitespace and anything unknown skip
  function automatic cmd_t decode(input logic [7:0] c);
    cmd_t r;
    r.op    = OP_SKIP;
    r.digit = '0;
    if ((c >= CH_UC_A && c <= CH_UC_Z) || (c >= CH_LC_A && c <= CH_LC_Z)) begin
      r.op = OP_ABORT;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      r.op    = OP_PUSH;
      r.digit = DIGIT_W'(c - CH_ZERO);
    end else if (c == CH_EQUAL) begin
      r.op = OP_EQ;
    end else if (c == CH_PLUS) begin
      r.op = OP_ADD;
    end else if (c == CH_MINUS) begin
      r.op = OP_SUB;
    end else if (c == CH_STAR) begin
      r.op = OP_MUL;
    end else if (c == CH_SLASH) begin
      r.op = OP_DIV;
    end
    return r;
  endfunction

  // Hold the request while the queue is full
  assign in_stall = q_full;
  assign q_cmd    = decode(char_code);
  assign q_push   = in_valid && !q_full && (q_cmd.op != OP_SKIP);

endmodule

@@ rtl/rsc_queue.sv @@
// Small command queue between the decoder and the execution unit.
`timescale 1ns / 1ps

module rsc_queue import rsc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  cmd_t          entries [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   fill;

  assign full       = (fill == (PW+1)'(QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head_cmd   = entries[rd_ptr];

  // Payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + (PW+1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (PW+1)'(1);
      end
    end
  end

endmodule

@@ rtl/rsc_div.sv @@
// Iterative signed divider, one quotient bit per cycle, truncating.
`timescale 1ns / 1ps

module rsc_div import rsc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              done,
  output logic [DATA_W-1:0] quotient
);

  localparam int SW = $clog2(DATA_W);

  logic              busy;
  logic [SW-1:0]     step;
  logic [DATA_W-1:0] num;
  logic [DATA_W-1:0] den;
  logic [DATA_W-1:0] rem;
  logic              neg;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   diff;

  // Restoring step: shift in next dividend bit and try subtract
  assign rem_sh = {rem, num[DATA_W-1]};
  assign diff   = rem_sh - {1'b0, den};

  // Magnitudes are divided; sign applied on the way out
  assign quotient = neg ? (~num + DATA_W'(1)) : num;

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend[DATA_W-1] ? (~dividend + DATA_W'(1)) : dividend;
      den <= divisor[DATA_W-1] ? (~divisor + DATA_W'(1)) : divisor;
      rem <= '0;
      neg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
    end else if (busy) begin
      if (!diff[DATA_W]) begin
        rem <= diff[DATA_W-1:0];
        num <= {num[DATA_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DATA_W-1:0];
        num <= {num[DATA_W-2:0], 1'b0};
      end
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + SW'(1);
        if (step == SW'(DATA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/rsc_back.sv @@
// Back end: operand stack, arithmetic and result register.
`timescale 1ns / 1ps
`include "rpn_stack_calculator_assert.svh"

module rsc_back import rsc_pkg::*; #(
  parameter int STACK_DEPTH = 128
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  cmd_t                       q_cmd,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [DATA_W-1:0]   value,
  output logic [STATUS_W-1:0]        status
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_DIV  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t              state;
  logic [CW-1:0]       count;     // occupied entries, top one lives in tos
  logic [DATA_W-1:0]   tos;
  op_t                 op;
  logic [DATA_W-1:0]   res_value;
  logic [STATUS_W-1:0] res_status;

  logic [CW-1:0]     count_m1;
  logic [CW-1:0]     count_m2;
  logic              stack_full;
  logic              take;
  logic              is_binop;
  logic              ram_wr_en;
  logic              ram_rd_en;
  logic [DATA_W-1:0] ram_rd_data;
  logic [DATA_W-1:0] sum;
  logic [DATA_W-1:0] dif;
  logic [DATA_W-1:0] prod;
  logic              div_start;
  logic              div_done;
  logic [DATA_W-1:0] div_quot;
  logic              out_load;

  assign count_m1   = count - CW'(1);
  assign count_m2   = count - CW'(2);
  assign stack_full = (count == CW'(STACK_DEPTH));

  // Pop the head request whenever idle and the queue holds one
  assign take  = (state == S_IDLE) && q_valid;
  assign q_pop = take;

  assign is_binop = (q_cmd.op == OP_ADD) || (q_cmd.op == OP_SUB) ||
                    (q_cmd.op == OP_MUL) || (q_cmd.op == OP_DIV);

  // Spill old top on push, fetch second operand for an operator
  assign ram_wr_en = take && (q_cmd.op == OP_PUSH) && !stack_full && (count != '0);
  assign ram_rd_en = take && is_binop && (count >= CW'(2));

  rsc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (count_m1[AW-1:0]),
    .wr_data (tos),
    .rd_en   (ram_rd_en),
    .rd_addr (count_m2[AW-1:0]),
    .rd_data (ram_rd_data)
  );

  // Operand a comes from memory, b is the top register
  assign sum  = ram_rd_data + tos;
  assign dif  = ram_rd_data - tos;
  assign prod = ram_rd_data * tos;

  assign div_start = (state == S_EXEC) && (op == OP_DIV) && (tos != '0);

  rsc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (ram_rd_data),
    .divisor  (tos),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign out_load = (state == S_EMIT) && (!out_valid || !out_stall);

  // Sequencer and stack pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (take) begin
            unique case (q_cmd.op)
              OP_PUSH: begin
                if (stack_full) begin
                  count <= '0;
                  state <= S_EMIT;
                end else begin
                  count <= count + CW'(1);
                end
              end
              OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                if (count < CW'(2)) begin
                  count <= '0;
                  state <= S_EMIT;
                end else begin
                  state <= S_EXEC;
                end
              end
              OP_EQ, OP_ABORT: begin
                count <= '0;
                state <= S_EMIT;
              end
              default: begin
              end
            endcase
          end
        end
        S_EXEC: begin
          if (op == OP_DIV) begin
            if (tos == '0) begin
              count <= '0;
              state <= S_EMIT;
            end else begin
              state <= S_DIV;
            end
          end else begin
            count <= count_m1;
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            count <= count_m1;
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Top of stack, latched op and pending result
  always_ff @(posedge clk) begin
    if (take) begin
      op <= q_cmd.op;
      unique case (q_cmd.op)
        OP_PUSH: begin
          tos        <= stack_full ? tos : DATA_W'(q_cmd.digit);
          res_value  <= '0;
          res_status <= ST_OVERFLOW;
        end
        OP_EQ: begin
          res_value  <= (count == '0) ? '0 : tos;
          res_status <= (count == '0) ? ST_UNDERFLOW : ST_OK;
        end
        OP_ABORT: begin
          res_value  <= '0;
          res_status <= ST_ABORT;
        end
        default: begin
          res_value  <= '0;
          res_status <= ST_UNDERFLOW;
        end
      endcase
    end else if (state == S_EXEC) begin
      unique case (op)
        OP_ADD:  tos <= sum;
        OP_SUB:  tos <= dif;
        OP_MUL:  tos <= prod;
        default: begin
          res_value  <= '0;
          res_status <= ST_DIVZERO;
        end
      endcase
    end else if ((state == S_DIV) && div_done) begin
      tos <= div_quot;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      value  <= signed'(res_value);
      status <= res_status;
    end
  end

  `RSC_ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CW'(STACK_DEPTH), "stack count past depth")
  `RSC_ASSERT_IMPLY(a_exec_operands, clk, rst, state == S_EXEC, count >= CW'(2), "operator without two operands")
  `RSC_ASSERT_IMPLY(a_div_op, clk, rst, state == S_DIV, op == OP_DIV, "divider wait on non-divide op")
  `RSC_ASSERT_NEXT(a_emit_clears, clk, rst, out_load, count == '0 && out_valid, "stack not empty after result")

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the RPN stack calculator.
`timescale 1ns / 1ps

module tb_top import rsc_pkg::*; ();

  localparam int STACK_DEPTH = 128;
  localparam int ITEM_TARGET = 1600;
  localparam int LONG_HOLD   = 400;
  localparam int MAX_REPORTS = 10;

  // Whitespace codes not in the package
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [DATA_W-1:0] MOST_NEG = 32'h8000_0000;

  typedef struct packed {
    logic [DATA_W-1:0]   value;
    logic [STATUS_W-1:0] status;
  } calc_result_t;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [7:0]               char_code = 8'h00;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] value;
  logic [STATUS_W-1:0]      status;

  // Character stream waiting to be sent
  logic [7:0]   char_q[$];

  // Shadow of the operand stack and the results it predicts
  logic [DATA_W-1:0] shadow_stack [STACK_DEPTH];
  int                shadow_depth = 0;
  calc_result_t      expected_results[$];

  int fail_count = 0;
  int in_gap = 0;
  int in_calm = 0;
  int out_wait = 0;
  int out_calm = 0;
  int run_cycles = 0;
  int hold_left = 0;
  wire long_hold = (hold_left != 0);

  rpn_stack_calculator #(
    .STACK_DEPTH(STACK_DEPTH)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_code (char_code),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .status    (status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bit is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= CH_UC_A && c <= CH_UC_Z) || (c >= CH_LC_A && c <= CH_LC_Z);
  endfunction

  function automatic bit is_operator(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
  endfunction

  // Wait drawn per request; calm stretches give back-to-back traffic
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, 2);
    return $urandom_range(0, 18);
  endfunction

  // Prediction ---------------------------------------------------------------

  task automatic queue_result(input logic [DATA_W-1:0] v, input logic [STATUS_W-1:0] st);
    calc_result_t r;
    r.value = v;
    r.status = st;
    expected_results.push_back(r);
    shadow_depth = 0;
  endtask

  task automatic evaluate_char(input logic [7:0] c);
    logic [DATA_W-1:0] lhs;
    logic [DATA_W-1:0] rhs;
    logic [DATA_W-1:0] res;
    if (is_space(c)) return;
    if (is_letter(c)) begin
      queue_result('0, ST_ABORT);
      return;
    end
    if (c >= CH_ZERO && c <= CH_NINE) begin
      if (shadow_depth >= STACK_DEPTH) begin
        queue_result('0, ST_OVERFLOW);
      end else begin
        shadow_stack[shadow_depth] = {28'd0, c[3:0]};
        shadow_depth++;
      end
      return;
    end
    if (c == CH_EQUAL) begin
      if (shadow_depth == 0) queue_result('0, ST_UNDERFLOW);
      else queue_result(shadow_stack[shadow_depth - 1], ST_OK);
      return;
    end
    if (!is_operator(c)) return;
    if (shadow_depth < 2) begin
      queue_result('0, ST_UNDERFLOW);
      return;
    end
    rhs = shadow_stack[shadow_depth - 1];
    lhs = shadow_stack[shadow_depth - 2];
    shadow_depth -= 2;
    case (c)
      CH_PLUS:  res = lhs + rhs;
      CH_MINUS: res = lhs - rhs;
      CH_STAR:  res = lhs * rhs;
      default: begin
        if (rhs == '0) begin
          queue_result('0, ST_DIVZERO);
          return;
        end
        // most negative / -1 wraps back onto itself
        if (lhs == MOST_NEG && rhs == '1) res = lhs;
        else res = $signed(lhs) / $signed(rhs);
      end
    endcase
    shadow_stack[shadow_depth] = res;
    shadow_depth++;
  endtask

  // Stimulus -----------------------------------------------------------------

  task automatic feed(input logic [7:0] c);
    char_q.push_back(c);
  endtask

  task automatic feed_str(input string s);
    for (int i = 0; i < s.len(); i++) feed(s[i]);
  endtask

  task automatic feed_digit();
    feed(8'(CH_ZERO + $urandom_range(0, 9)));
  endtask

  task automatic feed_letter();
    if ($urandom_range(0, 1) == 0) feed(8'(CH_UC_A + $urandom_range(0, 25)));
    else feed(8'(CH_LC_A + $urandom_range(0, 25)));
  endtask

  task automatic feed_operator();
    case ($urandom_range(0, 4))
      0: feed(CH_PLUS);
      1: feed(CH_MINUS);
      2: feed(CH_SLASH);
      default: feed(CH_STAR);
    endcase
  endtask

  // Occasional whitespace between tokens
  task automatic maybe_space();
    if ($urandom_range(0, 5) == 0) begin
      if ($urandom_range(0, 1) == 0) feed(CH_SPACE);
      else feed(8'(CH_TAB + $urandom_range(0, 4)));
    end
  endtask

  // Well-formed expression, sometimes with operands left below the top
  task automatic gen_expression();
    int pushes_left;
    int depth;
    bit keep_extra;
    pushes_left = $urandom_range(1, 12);
    depth = 0;
    keep_extra = ($urandom_range(0, 9) == 0);
    while (pushes_left > 0 || depth > 1) begin
      if (pushes_left == 0 && keep_extra) break;
      if (depth >= 2 && (pushes_left == 0 || $urandom_range(0, 2) == 0)) begin
        feed_operator();
        depth--;
      end else begin
        feed_digit();
        depth++;
        pushes_left--;
      end
      maybe_space();
    end
    feed(CH_EQUAL);
  endtask

  // Short or cut-off sequences
  task automatic gen_broken();
    case ($urandom_range(0, 3))
      0: begin
        if ($urandom_range(0, 1) == 0) feed_digit();
        feed_operator();
      end
      1: begin
        repeat ($urandom_range(0, 4)) feed_digit();
        feed_letter();
      end
      2: feed(CH_EQUAL);
      default: begin
        repeat ($urandom_range(1, 5)) feed_digit();
        if ($urandom_range(0, 1) == 0) feed_operator();
      end
    endcase
  endtask

  task automatic gen_noise();
    repeat ($urandom_range(1, 6)) feed(8'($urandom_range(0, 255)));
  endtask

  // Fill the stack to the brim, then overflow it or reduce and read it
  task automatic gen_deep_stack(input bit overflow);
    feed(CH_EQUAL);
    repeat (STACK_DEPTH) feed_digit();
    if (overflow) begin
      feed_digit();
    end else begin
      repeat ($urandom_range(0, 4)) feed_operator();
      feed(CH_EQUAL);
    end
  endtask

  // Build 0x80000000 as 0 - 2 * 8^10, then exercise the wrap corners
  task automatic gen_most_negative();
    feed_str("02");
    repeat (10) feed_str("8*");
    feed(CH_MINUS);
    case ($urandom_range(0, 3))
      0: feed_str("01-/");
      1: feed_str("1-");
      2: feed_str("2*");
      default: begin
        feed_digit();
        feed(CH_SLASH);
      end
    endcase
    feed(CH_EQUAL);
  endtask

  // Driver -------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && !in_stall) evaluate_char(char_code);
      if (!in_valid || !in_stall) begin
        if (in_gap > 0 && !long_hold) begin
          in_valid <= 1'b0;
          in_gap--;
        end else if (char_q.size() != 0) begin
          in_valid <= 1'b1;
          char_code <= char_q.pop_front();
          in_gap = draw_wait(in_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and checker ------------------------------------------------------

  always @(posedge clk) begin
    calc_result_t want;
    if (rst) begin
      out_wait = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: unexpected result value=%0d status=%0d", $realtime, value, status);
        end else begin
          want = expected_results.pop_front();
          if (value !== want.value || status !== want.status) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("%0t: mismatch value exp %0d got %0d, status exp %0d got %0d",
                       $realtime, $signed(want.value), value, want.status, status);
          end
        end
        out_wait = draw_wait(out_calm);
      end
      out_stall <= long_hold || (out_wait > 0);
      if (out_wait > 0) out_wait--;
    end
  end

  // Long receiver hold-offs while the sender keeps pushing
  always @(posedge clk) begin
    if (rst) begin
      run_cycles <= 0;
      hold_left <= 0;
    end else begin
      run_cycles <= run_cycles + 1;
      if (run_cycles == 2000 || run_cycles == 9000) hold_left <= LONG_HOLD;
      else if (hold_left > 0) hold_left <= hold_left - 1;
    end
  end

  // Stimulus build, reset and end of run
  initial begin
    int pick;
    // directed: every operation, truncation, digit extremes, errors, ignored codes
    feed_str("07-2/ =");
    feed_str("99*8+=");
    feed_str("50/");
    feed_str("=");
    feed_str("3+");
    feed_str("4Z");
    feed_str("12=");
    feed(8'h00);
    feed(8'hFF);
    feed(CH_TAB);
    feed(CH_CR);

    for (int round = 0; char_q.size() < ITEM_TARGET; round++) begin
      if (round % 60 == 30) begin
        gen_deep_stack(round % 120 == 30);
      end else if (round % 60 == 50) begin
        gen_most_negative();
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70) gen_expression();
        else if (pick < 82) gen_broken();
        else if (pick < 94) gen_noise();
        else gen_most_negative();
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (char_q.size() != 0 || in_valid || expected_results.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
